### hdl/bqc_pkg.sv
package bqc_pkg;

    // field and internal widths
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int DATA_W   = 32;                  // Q23.8 inner values
    localparam int PROD_W   = DATA_W + COEF_W;     // one multiplier product
    localparam int ACC_W    = PROD_W + 2;          // sum of two products plus rounding
    localparam int TAP_W    = ACC_W - 14;          // tap sum back in Q23.8
    localparam int SUM_W    = DATA_W + 5;          // inner value plus tap sum, before clamp
    localparam int OSUM_W   = DATA_W + 1;          // output rounding sum

    // fixed-point formats
    localparam int COEF_FRAC  = 14;
    localparam int INNER_FRAC = 8;
    localparam int GAIN_SH    = COEF_FRAC - INNER_FRAC;
    localparam int RND_GAIN   = 2 ** (GAIN_SH - 1);
    localparam int RND_TAP    = 2 ** (COEF_FRAC - 1);
    localparam int RND_OUT    = 2 ** (INNER_FRAC - 1);
    localparam logic signed [COEF_W-1:0] GAIN_Q14 = 16'sd7651;   // round(0.467 * 2^14)

    // sections and coefficient bank
    localparam int SECTIONS = 2;
    localparam int SEC_MAX  = 2;
    localparam int SEC_W    = 1;
    localparam int TAPS     = 4;
    localparam int TAP_IDX_W = 2;

    localparam logic [TAP_IDX_W-1:0] K_ZERO1 = 2'd0;
    localparam logic [TAP_IDX_W-1:0] K_ZERO2 = 2'd1;
    localparam logic [TAP_IDX_W-1:0] K_POLE1 = 2'd2;
    localparam logic [TAP_IDX_W-1:0] K_POLE2 = 2'd3;

    // register port
    localparam int ADDR_W  = 5;
    localparam int PDATA_W = 32;
    localparam int IDX_LSB = 2;

    typedef logic [COEF_W-1:0] t_coef;
    typedef t_coef [TAPS-1:0] t_sec_coef;
    typedef t_sec_coef [SEC_MAX-1:0] t_coef_bank;

    typedef enum logic [2:0] {
        M_GAIN,
        M_D1P1,
        M_D2P2,
        M_D1Z1,
        M_D2Z2
    } t_mul_sel;

    typedef struct packed {
        t_mul_sel         mul_sel;
        logic [SEC_W-1:0] sec;
        logic             clr_clip;
        logic             ld_x;
        logic             acc_load;
        logic             acc_add;
        logic             ld_w;
        logic             ld_y;
        logic             out_ld;
    } t_dp_cmd;

endpackage

### hdl/bqc_ctrl.sv
module bqc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_stall,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output bqc_pkg::t_dp_cmd o_cmd
);
    import bqc_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_P1   = 8'b0000_0010,
        S_P2   = 8'b0000_0100,
        S_Z1   = 8'b0000_1000,
        S_W    = 8'b0001_0000,
        S_Z2   = 8'b0010_0000,
        S_Y    = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [SEC_W-1:0] r_sec, n_sec;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state       = r_state;
        n_sec         = r_sec;
        o_cmd         = '0;
        o_cmd.mul_sel = M_GAIN;
        o_cmd.sec     = r_sec;
        case (r_state)
            S_IDLE: begin
                // multiplier takes the sample on the accepting edge
                if (i_in_valid) begin
                    o_cmd.clr_clip = 1'b1;
                    n_sec          = '0;
                    n_state        = S_P1;
                end
            end
            S_P1: begin
                o_cmd.ld_x    = (r_sec == '0);
                o_cmd.mul_sel = M_D1P1;
                n_state       = S_P2;
            end
            S_P2: begin
                o_cmd.acc_load = 1'b1;
                o_cmd.mul_sel  = M_D2P2;
                n_state        = S_Z1;
            end
            S_Z1: begin
                o_cmd.acc_add = 1'b1;
                o_cmd.mul_sel = M_D1Z1;
                n_state       = S_W;
            end
            S_W: begin
                o_cmd.ld_w     = 1'b1;
                o_cmd.acc_load = 1'b1;
                o_cmd.mul_sel  = M_D2Z2;
                n_state        = S_Z2;
            end
            S_Z2: begin
                o_cmd.acc_add = 1'b1;
                n_state       = S_Y;
            end
            S_Y: begin
                o_cmd.ld_y = 1'b1;
                if (r_sec == SEC_W'(SECTIONS - 1)) begin
                    n_state = S_OUT;
                end else begin
                    n_sec   = r_sec + 1'b1;
                    n_state = S_P1;
                end
            end
            S_OUT: begin
                // hold until the output word slot is free
                if (out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_ld) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sec       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sec       <= n_sec;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### hdl/bqc_dp.sv
module bqc_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  bqc_pkg::t_dp_cmd                     i_cmd,
    input  logic signed [bqc_pkg::SAMPLE_W-1:0]  i_sample_in,
    input  bqc_pkg::t_coef_bank                  i_coef,
    output logic signed [bqc_pkg::SAMPLE_W-1:0]  o_sample_out,
    output logic                                 o_clipped
);
    import bqc_pkg::*;

    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc, n_acc;
    logic signed [DATA_W-1:0]   r_x;
    logic signed [DATA_W-1:0]   r_w;
    logic signed [DATA_W-1:0]   r_d1 [SEC_MAX];
    logic signed [DATA_W-1:0]   r_d2 [SEC_MAX];
    logic                       r_clip;
    logic signed [SAMPLE_W-1:0] r_out;
    logic                       r_out_clip;

    logic signed [DATA_W-1:0]   mul_a;
    logic signed [COEF_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]   gain_sum;
    logic signed [DATA_W-1:0]   gain_x;
    logic signed [TAP_W-1:0]    tap;
    logic signed [SUM_W-1:0]    w_sum, y_sum;
    logic signed [DATA_W-1:0]   w_val, y_val;
    logic                       w_sat, y_sat;
    logic signed [OSUM_W-1:0]   o_sum;
    logic signed [OSUM_W-INNER_FRAC-1:0] o_shr;
    logic signed [SAMPLE_W-1:0] o_val;
    logic                       o_sat;

    always_comb begin
        mul_a = DATA_W'(i_sample_in);
        mul_b = GAIN_Q14;
        case (i_cmd.mul_sel)
            M_GAIN: begin
                mul_a = DATA_W'(i_sample_in);
                mul_b = GAIN_Q14;
            end
            M_D1P1: begin
                mul_a = r_d1[i_cmd.sec];
                mul_b = $signed(i_coef[i_cmd.sec][K_POLE1]);
            end
            M_D2P2: begin
                mul_a = r_d2[i_cmd.sec];
                mul_b = $signed(i_coef[i_cmd.sec][K_POLE2]);
            end
            M_D1Z1: begin
                mul_a = r_d1[i_cmd.sec];
                mul_b = $signed(i_coef[i_cmd.sec][K_ZERO1]);
            end
            M_D2Z2: begin
                mul_a = r_d2[i_cmd.sec];
                mul_b = $signed(i_coef[i_cmd.sec][K_ZERO2]);
            end
            default: begin
                mul_a = DATA_W'(i_sample_in);
                mul_b = GAIN_Q14;
            end
        endcase
    end

    // scaled sample, Q2.14 product brought to Q23.8
    assign gain_sum = r_prod + PROD_W'(RND_GAIN);
    assign gain_x   = gain_sum[DATA_W+GAIN_SH-1:GAIN_SH];

    // rounded tap sum, floor shift of the biased accumulator
    assign tap   = r_acc[ACC_W-1:COEF_FRAC];
    assign w_sum = SUM_W'(r_x) + SUM_W'(tap);
    assign y_sum = SUM_W'(r_w) + SUM_W'(tap);

    always_comb begin
        w_sat = !(&w_sum[SUM_W-1:DATA_W-1] || ~|w_sum[SUM_W-1:DATA_W-1]);
        y_sat = !(&y_sum[SUM_W-1:DATA_W-1] || ~|y_sum[SUM_W-1:DATA_W-1]);
        w_val = w_sat ? {w_sum[SUM_W-1], {(DATA_W-1){!w_sum[SUM_W-1]}}}
                      : w_sum[DATA_W-1:0];
        y_val = y_sat ? {y_sum[SUM_W-1], {(DATA_W-1){!y_sum[SUM_W-1]}}}
                      : y_sum[DATA_W-1:0];
    end

    assign o_sum = OSUM_W'(r_x) + OSUM_W'(RND_OUT);
    assign o_shr = o_sum[OSUM_W-1:INNER_FRAC];

    always_comb begin
        o_sat = !(&o_shr[OSUM_W-INNER_FRAC-1:SAMPLE_W-1]
                  || ~|o_shr[OSUM_W-INNER_FRAC-1:SAMPLE_W-1]);
        o_val = o_sat ? {o_shr[OSUM_W-INNER_FRAC-1], {(SAMPLE_W-1){!o_shr[OSUM_W-INNER_FRAC-1]}}}
                      : o_shr[SAMPLE_W-1:0];
    end

    always_comb begin
        n_acc = r_acc;
        if (i_cmd.acc_load) begin
            n_acc = ACC_W'(r_prod) + ACC_W'(RND_TAP);
        end else if (i_cmd.acc_add) begin
            n_acc = r_acc + ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        r_acc  <= n_acc;
        if (i_cmd.ld_x) begin
            r_x <= gain_x;
        end else if (i_cmd.ld_y) begin
            r_x <= y_val;
        end
        if (i_cmd.ld_w) begin
            r_w <= w_val;
        end
        if (i_cmd.clr_clip) begin
            r_clip <= 1'b0;
        end else if (i_cmd.ld_w) begin
            r_clip <= r_clip | w_sat;
        end else if (i_cmd.ld_y) begin
            r_clip <= r_clip | y_sat;
        end
        if (i_cmd.out_ld) begin
            r_out      <= o_val;
            r_out_clip <= r_clip | o_sat;
        end
    end

    // delay line of each section: shift once its output is formed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SEC_MAX; s++) begin
                r_d1[s] <= '0;
                r_d2[s] <= '0;
            end
        end else if (i_cmd.ld_y) begin
            r_d2[i_cmd.sec] <= r_d1[i_cmd.sec];
            r_d1[i_cmd.sec] <= r_w;
        end
    end

    assign o_sample_out = r_out;
    assign o_clipped    = r_out_clip;

endmodule

### hdl/biquad_cascade_filter_core.sv
// An accepted input word passes, per section, through states P1, P2, Z1, W, Z2 and Y;
// input stays stalled until its output word is loaded in S_OUT. One shared 32x16
// multiplier forms the gain product and four tap products per section.
// A finished word waits in the output register while the next input is taken.
// Synchronous active-low reset clears coefficients, section delays and control;
// no clearing pass is needed.
module biquad_cascade_filter_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [bqc_pkg::SAMPLE_W-1:0]  i_sample_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [bqc_pkg::SAMPLE_W-1:0]  o_sample_out,
    output logic                                 o_clipped,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bqc_pkg::ADDR_W-1:0]           paddr,
    input  logic [bqc_pkg::PDATA_W-1:0]          pwdata,
    output logic [bqc_pkg::PDATA_W-1:0]          prdata,
    output logic                                 pready
);
    import bqc_pkg::*;

    t_coef_bank                  r_coef;
    logic [SEC_W+TAP_IDX_W-1:0]  reg_idx;
    logic [SEC_W-1:0]            reg_sec;
    logic [TAP_IDX_W-1:0]        reg_tap;
    logic                        reg_wr;
    t_dp_cmd                     cmd;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:IDX_LSB];
    assign reg_sec = reg_idx[SEC_W+TAP_IDX_W-1:TAP_IDX_W];
    assign reg_tap = reg_idx[TAP_IDX_W-1:0];
    assign reg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (reg_wr) begin
            r_coef[reg_sec][reg_tap] <= pwdata[COEF_W-1:0];
        end
    end

    assign prdata = PDATA_W'($signed(r_coef[reg_sec][reg_tap]));

    bqc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    bqc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_sample_in  (i_sample_in),
        .i_coef       (r_coef),
        .o_sample_out (o_sample_out),
        .o_clipped    (o_clipped)
    );

endmodule

### hdl/bqc_chk.sv
module bqc_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_stall,
    input logic                                 o_out_valid,
    input logic                                 i_out_stall,
    input logic signed [bqc_pkg::SAMPLE_W-1:0]  o_sample_out,
    input logic                                 o_clipped
);

    // a taken word keeps the block busy on the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken twice in a row");

    // a new result appears only as the block turns free, after being busy
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> (!o_in_stall && $past(o_in_stall)))
        else $error("result shown without finished work");

    // reset leaves no result pending and the input open
    assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("reset state wrong");

    // a stalled result word holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_sample_out) && $stable(o_clipped)))
        else $error("stalled output word changed");

endmodule

bind biquad_cascade_filter_core bqc_chk u_bqc_chk (.*);
